### rtl/opcc_pkg.sv
// Shared types, codes and constants of the outgoing packet capture classifier.
// Has no dependencies; every other file except opcc_ram refers to it by scoped names.
package opcc_pkg;

    // item kinds carried on s_tuser
    localparam logic [1:0] ACT_WR_IF    = 2'd0;
    localparam logic [1:0] ACT_WR_PF    = 2'd1;
    localparam logic [1:0] ACT_CLASSIFY = 2'd2;

    // verdict codes
    localparam logic [1:0] V_DROP  = 2'd0;
    localparam logic [1:0] V_IND   = 2'd1;
    localparam logic [1:0] V_MC    = 2'd2;
    localparam logic [1:0] V_WRITE = 2'd3;

    // packet qualifiers
    localparam logic [2:0]  PKT_OUTGOING = 3'd4;
    localparam logic [15:0] PROTO_IPV4   = 16'h0800;
    localparam logic [31:0] MC_LOW       = 32'he000_0000;
    localparam logic [31:0] MC_END       = 32'hf000_0000;
    localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;

    // capture lengths
    localparam logic [15:0] SNAP_NONE = 16'd0;
    localparam logic [15:0] SNAP_IND  = 16'd68;
    localparam logic [15:0] SNAP_FULL = 16'd65535;

    localparam int IN_W  = 192;
    localparam int OUT_W = 24;

    // input item fields, first field in the high bits
    typedef struct packed {
        logic [31:0] pkt_saddr;
        logic [31:0] pkt_daddr;
        logic [31:0] pkt_ifindex;
        logic [15:0] pkt_protocol;
        logic [2:0]  pkt_type;
        logic [5:0]  entry_prefix_len;
        logic [31:0] entry_prefix_addr;
        logic        entry_mcast;
        logic [31:0] entry_ifindex;
        logic        entry_valid;
        logic [4:0]  slot;
    } opcc_item_t;

    // interface table word (valid kept in flip-flops)
    typedef struct packed {
        logic        mcast;
        logic [31:0] ifindex;
    } opcc_iface_t;

    // prefix table word (valid kept in flip-flops)
    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] addr;
    } opcc_prefix_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       scan_clear;
        logic       scan_if;
        logic       scan_pf;
        logic       emit;
        logic [1:0] verdict;
    } opcc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pkt_ok;
        logic mc_dst;
        logic scan_done;
        logic scan_hit;
        logic hit_mcast;
        logic out_free;
    } opcc_sts_t;

    // capture length that goes with a verdict
    function automatic logic [15:0] snap_of(input logic [1:0] verdict);
        logic [15:0] snap;
        case (verdict)
            V_IND:   snap = SNAP_IND;
            V_MC:    snap = SNAP_FULL;
            default: snap = SNAP_NONE;
        endcase
        return snap;
    endfunction

endpackage

### rtl/outgoing_packet_capture_classifier.sv
// Top level of the outgoing packet capture classifier.
// Uses opcc_pkg, opcc_ctrl, opcc_datapath (which holds two opcc_ram tables).
//
// Each item on the slave stream either writes an interface table entry
// (s_tuser 0), writes a local prefix table entry (s_tuser 1) or classifies a
// packet (s_tuser 2); every item gives exactly one result on the master
// stream: verdict 3 for a write, otherwise drop (0), capture 68 bytes (1) or
// capture whole (2) with the matching snap length. Both tables come out of
// reset with every entry invalid and need no clearing pass. The block works
// on one item at a time. A classify drops a packet that is not outgoing IPv4
// without a scan; otherwise it walks the tables, each through its single read
// port, one entry per cycle, stopping at the first hit. A new item is accepted
// while the previous result still waits in the output register.
module outgoing_packet_capture_classifier #(
    parameter int IFACE_ENTRIES  = 16,
    parameter int PREFIX_ENTRIES = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // slot, entry_valid, entry_ifindex, entry_mcast, entry_prefix_addr,
    // entry_prefix_len, pkt_type, pkt_protocol, pkt_ifindex, pkt_daddr, pkt_saddr
    input  logic [opcc_pkg::IN_W-1:0]  s_tdata,
    // action
    input  logic [1:0]                 s_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // verdict, snap_length, zero fill
    output logic [opcc_pkg::OUT_W-1:0] m_tdata
);

    opcc_pkg::opcc_cmd_t  cmd;
    opcc_pkg::opcc_sts_t  sts;
    opcc_pkg::opcc_item_t item;
    logic [1:0]           out_verdict;
    logic [15:0]          out_snap;

    assign item = opcc_pkg::opcc_item_t'(s_tdata);

    opcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .action   (s_tuser),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    opcc_datapath #(
        .IFACE_ENTRIES  (IFACE_ENTRIES),
        .PREFIX_ENTRIES (PREFIX_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .action      (s_tuser),
        .cmd         (cmd),
        .sts         (sts),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_verdict (out_verdict),
        .out_snap    (out_snap)
    );

    // result packing, verdict in the low bits
    assign m_tdata = {6'd0, out_snap, out_verdict};

endmodule

### rtl/opcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module opcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/opcc_datapath.sv
// Datapath: item registers, both tables with their valid bits, the table
// scanner and the output register. Uses opcc_pkg and opcc_ram.
module opcc_datapath #(
    parameter int IFACE_ENTRIES  = 16,
    parameter int PREFIX_ENTRIES = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  opcc_pkg::opcc_item_t   item,
    input  logic [1:0]             action,
    input  opcc_pkg::opcc_cmd_t    cmd,
    output opcc_pkg::opcc_sts_t    sts,
    input  logic                   m_tready,
    output logic                   out_valid,
    output logic [1:0]             out_verdict,
    output logic [15:0]            out_snap
);

    localparam int IF_AW  = IFACE_ENTRIES > 1 ? $clog2(IFACE_ENTRIES) : 1;
    localparam int PF_AW  = PREFIX_ENTRIES > 1 ? $clog2(PREFIX_ENTRIES) : 1;
    localparam int MAX_N  = IFACE_ENTRIES > PREFIX_ENTRIES ? IFACE_ENTRIES : PREFIX_ENTRIES;
    localparam int CNT_W  = $clog2(MAX_N + 1);
    localparam int SLOT_W = 7;

    // packet fields held for the classify
    logic [2:0]  type_reg;
    logic [15:0] proto_reg;
    logic [31:0] ifx_reg;
    logic [31:0] daddr_reg;
    logic [31:0] saddr_reg;

    // table valid bits and writes
    logic [IFACE_ENTRIES-1:0]  if_valid_reg;
    logic [PREFIX_ENTRIES-1:0] pf_valid_reg;
    logic [SLOT_W-1:0]         slot_ext;
    logic                      if_we;
    logic                      pf_we;

    // scanner
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] pidx_reg;
    logic [CNT_W-1:0] pidx_next;
    logic             pend_reg;
    logic             pend_next;
    logic [CNT_W-1:0] limit;
    logic             scan_on;
    logic             issue;
    logic             match_if;
    logic             match_pf;
    logic             hit_now;

    // table read data
    logic [32:0]            if_rdata;
    logic [37:0]            pf_rdata;
    opcc_pkg::opcc_iface_t  if_rd;
    opcc_pkg::opcc_prefix_t pf_rd;
    logic [31:0]            pf_mask;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  verdict_reg;
    logic [15:0] snap_reg;

    // table writes happen in the cycle the item is taken
    assign slot_ext = SLOT_W'(item.slot);
    assign if_we = cmd.load && (action == opcc_pkg::ACT_WR_IF)
                   && (slot_ext < SLOT_W'(IFACE_ENTRIES));
    assign pf_we = cmd.load && (action == opcc_pkg::ACT_WR_PF)
                   && (slot_ext < SLOT_W'(PREFIX_ENTRIES));

    opcc_ram #(
        .WIDTH (33),
        .DEPTH (IFACE_ENTRIES)
    ) u_if_ram (
        .clk   (clk),
        .we    (if_we),
        .waddr (slot_ext[IF_AW-1:0]),
        .wdata ({item.entry_mcast, item.entry_ifindex}),
        .raddr (cnt_reg[IF_AW-1:0]),
        .rdata (if_rdata)
    );

    opcc_ram #(
        .WIDTH (38),
        .DEPTH (PREFIX_ENTRIES)
    ) u_pf_ram (
        .clk   (clk),
        .we    (pf_we),
        .waddr (slot_ext[PF_AW-1:0]),
        .wdata ({item.entry_prefix_len, item.entry_prefix_addr}),
        .raddr (cnt_reg[PF_AW-1:0]),
        .rdata (pf_rdata)
    );

    assign if_rd = opcc_pkg::opcc_iface_t'(if_rdata);
    assign pf_rd = opcc_pkg::opcc_prefix_t'(pf_rdata);

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            if_valid_reg <= '0;
            pf_valid_reg <= '0;
        end
        else
        begin
            if (if_we)
            begin
                if_valid_reg[slot_ext[IF_AW-1:0]] <= item.entry_valid;
            end
            if (pf_we)
            begin
                pf_valid_reg[slot_ext[PF_AW-1:0]] <= item.entry_valid;
            end
        end
    end

    // packet field capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            type_reg  <= item.pkt_type;
            proto_reg <= item.pkt_protocol;
            ifx_reg   <= item.pkt_ifindex;
            daddr_reg <= item.pkt_daddr;
            saddr_reg <= item.pkt_saddr;
        end
    end

    // entry compare on data read in the previous cycle;
    // a length of 32 or more leaves an all-ones mask, zero an empty one
    assign pf_mask  = ~(opcc_pkg::ALL_ONES >> pf_rd.len);
    assign match_if = pend_reg && if_valid_reg[pidx_reg[IF_AW-1:0]]
                      && (if_rd.ifindex == ifx_reg);
    assign match_pf = pend_reg && pf_valid_reg[pidx_reg[PF_AW-1:0]]
                      && (((saddr_reg ^ pf_rd.addr) & pf_mask) == 32'd0);

    // scan sequencing: one read issued per cycle, stop at the first hit
    always_comb
    begin
        scan_on   = cmd.scan_if || cmd.scan_pf;
        limit     = cmd.scan_if ? CNT_W'(IFACE_ENTRIES) : CNT_W'(PREFIX_ENTRIES);
        hit_now   = cmd.scan_if ? match_if : (cmd.scan_pf && match_pf);
        issue     = scan_on && (cnt_reg < limit) && !hit_now;
        cnt_next  = cnt_reg;
        pidx_next = pidx_reg;
        pend_next = issue;
        if (issue)
        begin
            cnt_next  = cnt_reg + CNT_W'(1);
            pidx_next = cnt_reg;
        end
        if (cmd.scan_clear)
        begin
            cnt_next  = '0;
            pend_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pidx_reg <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            pidx_reg <= pidx_next;
            pend_reg <= pend_next;
        end
    end

    // output register, freed when the result is taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            verdict_reg <= cmd.verdict;
            snap_reg    <= opcc_pkg::snap_of(cmd.verdict);
        end
    end

    // status to the controller
    assign sts.pkt_ok    = (type_reg == opcc_pkg::PKT_OUTGOING)
                           && (proto_reg == opcc_pkg::PROTO_IPV4);
    assign sts.mc_dst    = (daddr_reg >= opcc_pkg::MC_LOW) && (daddr_reg < opcc_pkg::MC_END);
    assign sts.scan_hit  = hit_now;
    assign sts.scan_done = hit_now || ((cnt_reg >= limit) && !pend_reg);
    assign sts.hit_mcast = if_rd.mcast;
    assign sts.out_free  = !out_valid_reg || m_tready;

    assign out_valid   = out_valid_reg;
    assign out_verdict = verdict_reg;
    assign out_snap    = snap_reg;

endmodule

### rtl/opcc_ctrl.sv
// Controller state machine: takes items, runs the interface and prefix scans
// and decides the verdict. Uses opcc_pkg; drives opcc_datapath by commands.
module opcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic [1:0]          action,
    output logic                s_tready,
    output opcc_pkg::opcc_cmd_t cmd,
    input  opcc_pkg::opcc_sts_t sts
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_IF_SCAN = 3'd2;
    localparam logic [2:0] ST_PF_SCAN = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [1:0] verdict_reg;
    logic [1:0] verdict_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        verdict_next   = verdict_reg;
        cmd            = '0;
        cmd.verdict    = verdict_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load = 1'b1;
                    case (action) inside
                        opcc_pkg::ACT_WR_IF, opcc_pkg::ACT_WR_PF:
                        begin
                            verdict_next = opcc_pkg::V_WRITE;
                            state_next   = ST_EMIT;
                        end
                        opcc_pkg::ACT_CLASSIFY:
                        begin
                            state_next = ST_CHECK;
                        end
                        default:
                        begin
                            verdict_next = opcc_pkg::V_DROP;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_CHECK:
            begin
                cmd.scan_clear = 1'b1;
                if (sts.pkt_ok)
                begin
                    state_next = ST_IF_SCAN;
                end
                else
                begin
                    verdict_next = opcc_pkg::V_DROP;
                    state_next   = ST_EMIT;
                end
            end
            ST_IF_SCAN:
            begin
                cmd.scan_if = 1'b1;
                if (sts.scan_done)
                begin
                    if (!sts.scan_hit)
                    begin
                        verdict_next = opcc_pkg::V_DROP;
                        state_next   = ST_EMIT;
                    end
                    else if (sts.mc_dst)
                    begin
                        verdict_next = sts.hit_mcast ? opcc_pkg::V_MC : opcc_pkg::V_DROP;
                        state_next   = ST_EMIT;
                    end
                    else
                    begin
                        cmd.scan_clear = 1'b1;
                        state_next     = ST_PF_SCAN;
                    end
                end
            end
            ST_PF_SCAN:
            begin
                cmd.scan_pf = 1'b1;
                if (sts.scan_done)
                begin
                    verdict_next = sts.scan_hit ? opcc_pkg::V_DROP : opcc_pkg::V_IND;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            verdict_reg <= opcc_pkg::V_DROP;
        end
        else
        begin
            state_reg   <= state_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

### sim/tb_outgoing_packet_capture_classifier.sv
// Testbench for the outgoing packet capture classifier: table writes and packet
// classifications checked against an in-bench prediction of verdict and snap length.
// Depends on opcc_pkg and the outgoing_packet_capture_classifier RTL only.
`timescale 1ns / 100ps

module tb_outgoing_packet_capture_classifier;

    localparam int IFACE_SLOTS  = 16;
    localparam int PREFIX_SLOTS = 32;
    localparam int RANDOM_ITEMS = 700;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYCLES = 60;

    // action code the block leaves unused
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] action;
        opcc_pkg::opcc_item_t fields;
        bit         drain_first;
    } request_t;

    typedef struct packed {
        logic [1:0]  verdict;
        logic [15:0] snap;
    } capture_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [opcc_pkg::IN_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [opcc_pkg::OUT_W-1:0] m_tdata;

    outgoing_packet_capture_classifier #(
        .IFACE_ENTRIES  (IFACE_SLOTS),
        .PREFIX_ENTRIES (PREFIX_SLOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // predicted table contents
    bit          iface_valid [IFACE_SLOTS];
    bit          iface_mcast [IFACE_SLOTS];
    logic [31:0] iface_index [IFACE_SLOTS];
    bit          pfx_valid [PREFIX_SLOTS];
    logic [31:0] pfx_addr [PREFIX_SLOTS];
    logic [5:0]  pfx_len [PREFIX_SLOTS];

    request_t        pending_requests [$];
    capture_result_t expected_captures [$];
    logic [31:0]     written_prefixes [$];
    bit              drain_request = 1'b0;

    request_t        cur_req;
    capture_result_t want;
    int burst_left;
    int gap_left;
    int rx_mode;
    int rx_mode_left;
    int hold_left;
    int rx_seen;
    bit hold_done;
    logic [7:0] rx_phase;
    int stall_cycles;
    int results_checked;
    int mismatches;

    // clock
    initial
    begin
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // true when src falls inside base/len; lengths above 32 mean exact match
    function automatic bit source_in_prefix(logic [31:0] src, logic [31:0] base,
                                            logic [5:0] len);
        logic [31:0] host;
        bit hit;
        if (len >= 6'd32)
            hit = (src == base);
        else
        begin
            host = (len == 6'd0) ? 32'hffff_ffff : (32'hffff_ffff >> len);
            hit = (src >= (base & ~host)) && (src <= (base | host));
        end
        return hit;
    endfunction

    function automatic logic [1:0] classify_verdict(opcc_pkg::opcc_item_t f);
        int hit;
        logic [1:0] v;
        hit = -1;
        v = opcc_pkg::V_DROP;
        if (f.pkt_type == opcc_pkg::PKT_OUTGOING && f.pkt_protocol == opcc_pkg::PROTO_IPV4)
        begin
            // lowest matching slot wins
            for (int i = IFACE_SLOTS - 1; i >= 0; i--)
                if (iface_valid[i] && iface_index[i] == f.pkt_ifindex)
                    hit = i;
            if (hit >= 0)
            begin
                if (f.pkt_daddr >= opcc_pkg::MC_LOW && f.pkt_daddr < opcc_pkg::MC_END)
                    v = iface_mcast[hit] ? opcc_pkg::V_MC : opcc_pkg::V_DROP;
                else
                begin
                    v = opcc_pkg::V_IND;
                    for (int j = 0; j < PREFIX_SLOTS; j++)
                        if (pfx_valid[j] && source_in_prefix(f.pkt_saddr, pfx_addr[j], pfx_len[j]))
                            v = opcc_pkg::V_DROP;
                end
            end
        end
        return v;
    endfunction

    // applies one item to the predicted tables and returns its result
    function automatic capture_result_t predict_capture(logic [1:0] action,
                                                        opcc_pkg::opcc_item_t f);
        capture_result_t r;
        r.verdict = opcc_pkg::V_DROP;
        r.snap = opcc_pkg::SNAP_NONE;
        case (action)
            opcc_pkg::ACT_WR_IF:
            begin
                if (f.slot < IFACE_SLOTS)
                begin
                    iface_valid[f.slot] = f.entry_valid;
                    iface_index[f.slot] = f.entry_ifindex;
                    iface_mcast[f.slot] = f.entry_mcast;
                end
                r.verdict = opcc_pkg::V_WRITE;
            end
            opcc_pkg::ACT_WR_PF:
            begin
                if (f.slot < PREFIX_SLOTS)
                begin
                    pfx_valid[f.slot] = f.entry_valid;
                    pfx_addr[f.slot] = f.entry_prefix_addr;
                    pfx_len[f.slot] = f.entry_prefix_len;
                end
                r.verdict = opcc_pkg::V_WRITE;
            end
            opcc_pkg::ACT_CLASSIFY:
            begin
                r.verdict = classify_verdict(f);
                if (r.verdict == opcc_pkg::V_IND)
                    r.snap = opcc_pkg::SNAP_IND;
                else if (r.verdict == opcc_pkg::V_MC)
                    r.snap = opcc_pkg::SNAP_FULL;
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // item generation
    // ------------------------------------------------------------------

    function automatic opcc_pkg::opcc_item_t noise_fields();
        opcc_pkg::opcc_item_t f;
        f = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return f;
    endfunction

    task automatic push_request(logic [1:0] action, opcc_pkg::opcc_item_t f);
        request_t r;
        r.action = action;
        r.fields = f;
        r.drain_first = drain_request || ($urandom_range(0, 99) == 0);
        drain_request = 1'b0;
        pending_requests.push_back(r);
    endtask

    task automatic add_iface(logic [4:0] slot, bit valid, logic [31:0] idx, bit mcast);
        opcc_pkg::opcc_item_t f;
        f = noise_fields();
        f.slot = slot;
        f.entry_valid = valid;
        f.entry_ifindex = idx;
        f.entry_mcast = mcast;
        push_request(opcc_pkg::ACT_WR_IF, f);
    endtask

    task automatic add_prefix(logic [4:0] slot, bit valid, logic [31:0] addr,
                              logic [5:0] len);
        opcc_pkg::opcc_item_t f;
        f = noise_fields();
        f.slot = slot;
        f.entry_valid = valid;
        f.entry_prefix_addr = addr;
        f.entry_prefix_len = len;
        written_prefixes.push_back(addr);
        push_request(opcc_pkg::ACT_WR_PF, f);
    endtask

    task automatic add_packet(logic [2:0] ptype, logic [15:0] proto, logic [31:0] ifx,
                              logic [31:0] dst, logic [31:0] src);
        opcc_pkg::opcc_item_t f;
        f = noise_fields();
        f.pkt_type = ptype;
        f.pkt_protocol = proto;
        f.pkt_ifindex = ifx;
        f.pkt_daddr = dst;
        f.pkt_saddr = src;
        push_request(opcc_pkg::ACT_CLASSIFY, f);
    endtask

    function automatic logic [31:0] pick_ifindex();
        logic [31:0] idx;
        case ($urandom_range(0, 7))
            0: idx = 32'h0000_0000;
            1: idx = 32'h0000_0001;
            2: idx = 32'h0000_0002;
            3: idx = 32'h8000_0001;
            4: idx = 32'hffff_fffe;
            5: idx = 32'hffff_ffff;
            6: idx = 32'h0000_0002;
            default: idx = $urandom();
        endcase
        return idx;
    endfunction

    function automatic logic [5:0] pick_prefix_len();
        int r;
        logic [5:0] len;
        r = $urandom_range(0, 99);
        if (r < 4)
            len = 6'($urandom_range(0, 7));
        else if (r < 94)
            len = 6'($urandom_range(8, 32));
        else
            len = 6'($urandom_range(33, 63));
        return len;
    endfunction

    function automatic logic [31:0] pick_daddr();
        int r;
        logic [31:0] dst;
        r = $urandom_range(0, 99);
        if (r < 20)
            dst = {4'he, 28'($urandom())};
        else if (r < 30)
        begin
            case ($urandom_range(0, 3))
                0: dst = 32'hdfff_ffff;
                1: dst = opcc_pkg::MC_LOW;
                2: dst = 32'hefff_ffff;
                default: dst = opcc_pkg::MC_END;
            endcase
        end
        else
            dst = $urandom();
        return dst;
    endfunction

    function automatic logic [31:0] pick_saddr();
        logic [31:0] src;
        if (written_prefixes.size() != 0 && $urandom_range(0, 9) < 4)
            src = written_prefixes[$urandom_range(0, written_prefixes.size() - 1)]
                  ^ 32'($urandom_range(0, 255));
        else
            src = $urandom();
        return src;
    endfunction

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int pick;
        logic [4:0] slot;
        opcc_pkg::opcc_item_t f;

        // empty tables: everything drops
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'h0, 32'h0a00_0001,
                   32'h0a00_0002);
        // interface table extremes, an out of range slot and a duplicate index
        add_iface(5'd0, 1'b1, 32'hffff_ffff, 1'b1);
        add_iface(5'd15, 1'b1, 32'h0000_0000, 1'b0);
        add_iface(5'd31, 1'b1, 32'h0000_0007, 1'b1);
        add_iface(5'd3, 1'b1, 32'hffff_ffff, 1'b0);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'h0000_0007,
                   32'h0101_0101, 32'h0);
        // multicast edges
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   opcc_pkg::MC_LOW, 32'hffff_ffff);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'h0, 32'hefff_ffff, 32'h0);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   opcc_pkg::MC_END, 32'h0);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'hdfff_ffff, 32'h1);
        // not outgoing, not ipv4
        add_packet(3'd3, opcc_pkg::PROTO_IPV4, 32'hffff_ffff, 32'h0101_0101, 32'h0);
        add_packet(3'd7, 16'hffff, 32'hffff_ffff, 32'h0101_0101, 32'h0);
        add_packet(opcc_pkg::PKT_OUTGOING, 16'h0801, 32'hffff_ffff, 32'h0101_0101, 32'h0);
        // /8 prefix edges
        add_prefix(5'd0, 1'b1, 32'h0a12_3456, 6'd8);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'h0aff_ffff);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'h0b00_0000);
        // zero length prefix covers everything, first invalid then valid
        add_prefix(5'd31, 1'b0, 32'h1234_5678, 6'd0);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'h7f00_0001);
        add_prefix(5'd31, 1'b1, 32'h1234_5678, 6'd0);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'h7f00_0001);
        // overlong length acts as exact match
        add_prefix(5'd31, 1'b1, 32'hc0a8_0001, 6'd63);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'hc0a8_0001);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'h0101_0101, 32'hc0a8_0002);
        add_prefix(5'd1, 1'b1, 32'hffff_ffff, 6'd32);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'h0,
                   32'h0101_0101, 32'hffff_ffff);
        // unused action leaves tables alone
        f = noise_fields();
        push_request(ACT_UNUSED, f);
        // dropping slot 0 hands the index to slot 3, which has no multicast
        drain_request = 1'b1;
        add_iface(5'd0, 1'b0, 32'hffff_ffff, 1'b1);
        add_packet(opcc_pkg::PKT_OUTGOING, opcc_pkg::PROTO_IPV4, 32'hffff_ffff,
                   32'he000_00fb, 32'h0);

        // random part
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                slot = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(16, 31))
                                                    : 5'($urandom_range(0, 15));
                add_iface(slot, $urandom_range(0, 3) != 0, pick_ifindex(),
                          1'($urandom_range(0, 1)));
            end
            else if (pick < 35)
                add_prefix(5'($urandom_range(0, 31)), $urandom_range(0, 2) != 0,
                           $urandom(), pick_prefix_len());
            else if (pick < 97)
                add_packet(($urandom_range(0, 4) != 0) ? opcc_pkg::PKT_OUTGOING
                                                       : 3'($urandom_range(0, 7)),
                           ($urandom_range(0, 4) != 0) ? opcc_pkg::PROTO_IPV4
                                                       : 16'($urandom()),
                           ($urandom_range(0, 6) != 0) ? pick_ifindex() : $urandom(),
                           pick_daddr(), pick_saddr());
            else
            begin
                f = noise_fields();
                push_request(ACT_UNUSED, f);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // sampled off the active edge to stay clear of the driver
        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid)
            @(negedge clk);
        while (expected_captures.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("outgoing_packet_capture_classifier verification clean");
        else
            $display("outgoing_packet_capture_classifier verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // driver: bursts with random gaps, optional wait for drain
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left = 0;
            for (int i = 0; i < IFACE_SLOTS; i++)
            begin
                iface_valid[i] = 1'b0;
                iface_mcast[i] = 1'b0;
                iface_index[i] = '0;
            end
            for (int j = 0; j < PREFIX_SLOTS; j++)
            begin
                pfx_valid[j] = 1'b0;
                pfx_addr[j] = '0;
                pfx_len[j] = '0;
            end
        end
        else
        begin
            // item taken: predict it and count down the burst
            if (s_tvalid && s_tready)
            begin
                expected_captures.push_back(predict_capture(cur_req.action, cur_req.fields));
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            // present the next item once the current one is gone
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first && expected_captures.size() != 0))
                begin
                    cur_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur_req.fields;
                    s_tuser <= cur_req.action;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: changing stall pattern plus one long hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_mode = 0;
            rx_mode_left = 100;
            hold_left = 0;
            rx_seen = 0;
            hold_done = 1'b0;
            rx_phase = '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                rx_seen++;
            if (!hold_done && rx_seen >= 250)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (rx_mode_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(30, 200);
            end
            else
                rx_mode_left--;
            rx_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= (rx_phase[2:0] != 3'd5 && rx_phase[2:0] != 3'd6);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("mismatch at result %0d: %s", results_checked, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_captures.size() == 0)
                report_mismatch($sformatf("result %h with nothing outstanding", m_tdata));
            else
            begin
                want = expected_captures.pop_front();
                if (m_tdata[1:0] != want.verdict)
                    report_mismatch($sformatf("verdict %0d, predicted %0d",
                                              m_tdata[1:0], want.verdict));
                if (m_tdata[17:2] != want.snap)
                    report_mismatch($sformatf("snap length %0d, predicted %0d",
                                              m_tdata[17:2], want.snap));
            end
            results_checked++;
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("outgoing_packet_capture_classifier verification failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
